@@ src/dqpd_pkg.sv @@
// Shared types and codes for the deque with prefix duplicate.
`timescale 1ns / 1ps

package dqpd_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_DUP        = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;
        logic    push_front;
        logic    push_back;
        logic    pop_rd;
        logic    pop_cap;
        logic    set_stat;
        t_status stat;
        logic    copy_start;
        logic    copy_run;
        logic    copy_commit;
        logic    load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic full;
        logic empty;
        logic k_zero;
        logic k_short;
        logic k_over;
        logic copy_done;
    } t_sts;

endpackage

@@ src/dqpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dqpd_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/dqpd_ctrl.sv @@
// Request sequencer: decides each request and steps pop and copy work.
`timescale 1ns / 1ps

module dqpd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    input  dqpd_pkg::t_sts i_sts,
    output dqpd_pkg::t_cmd o_cmd
);

    import dqpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP_WAIT,
        S_COPY,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_req = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.set_stat = 1'b1;
                cmd.stat     = ST_OK;
                n_state      = S_RESP;
                unique case (i_sts.req)
                    REQ_PUSH_FRONT: begin
                        if (i_sts.full) cmd.stat = ST_FULL;
                        else cmd.push_front = 1'b1;
                    end
                    REQ_PUSH_BACK: begin
                        if (i_sts.full) cmd.stat = ST_FULL;
                        else cmd.push_back = 1'b1;
                    end
                    REQ_POP_FRONT: begin
                        if (i_sts.empty) begin
                            cmd.stat = ST_EMPTY;
                        end else begin
                            cmd.pop_rd = 1'b1;
                            n_state    = S_POP_WAIT;
                        end
                    end
                    REQ_DUP: begin
                        if (i_sts.k_zero) begin
                            cmd.stat = ST_OK;
                        end else if (i_sts.k_short) begin
                            cmd.stat = ST_SHORT;
                        end else if (i_sts.k_over) begin
                            cmd.stat = ST_FULL;
                        end else begin
                            cmd.copy_start = 1'b1;
                            n_state        = S_COPY;
                        end
                    end
                    default: cmd.stat = ST_OK;
                endcase
            end
            S_POP_WAIT: begin
                cmd.pop_cap = 1'b1;
                n_state     = S_RESP;
            end
            S_COPY: begin
                if (i_sts.copy_done) begin
                    cmd.copy_commit = 1'b1;
                    n_state         = S_RESP;
                end else begin
                    cmd.copy_run = 1'b1;
                end
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ src/dqpd_dp.sv @@
// Datapath: ring pointers, count, entry RAM, copy engine and result register.
`timescale 1ns / 1ps

module dqpd_dp #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_req_type,
    input  logic [31:0]    i_item_value,
    input  logic [8:0]     i_copy_count,
    input  dqpd_pkg::t_cmd i_cmd,
    output dqpd_pkg::t_sts o_sts,
    output logic [31:0]    o_popped_value,
    output logic [1:0]     o_status,
    output logic           o_is_empty,
    output logic [8:0]     o_entry_count
);

    import dqpd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;
    localparam int KW = ((CW > 9) ? CW : 9) + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);
    localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

    // reduce a sum below 2*DEPTH into ring range
    function automatic logic [AW-1:0] wrap(input logic [XW-1:0] s);
        logic [XW-1:0] t;
        t = (s >= DEPTH_X) ? (s - DEPTH_X) : s;
        return t[AW-1:0];
    endfunction

    t_req          r_req;
    logic [DATA_W-1:0] r_item;
    logic [8:0]    r_k;
    logic [AW-1:0] r_front;
    logic [CW-1:0] r_count;

    logic [AW-1:0] r_src, r_dst, r_new_front, r_wr_addr;
    logic [8:0]    r_idx;
    logic          r_wr_pend;

    logic [DATA_W-1:0] r_pop;
    t_status       r_stat;

    logic [31:0]   r_o_pop;
    t_status       r_o_stat;
    logic          r_o_empty;
    logic [8:0]    r_o_count;

    logic [63:0]   item64, pop64, cnt64;
    logic [AW-1:0] front_dec, front_inc, back_addr, dup_front, src_inc, dst_inc;
    logic [KW-1:0] k_ext, cnt_ext;
    logic          rd_issue;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    assign item64 = {32'b0, i_item_value};
    assign pop64  = 64'(r_pop);
    assign cnt64  = 64'(r_count);

    assign front_dec = wrap(XW'(r_front) + DEPTH_X - XW'(1));
    assign front_inc = wrap(XW'(r_front) + XW'(1));
    assign back_addr = wrap(XW'(r_front) + XW'(r_count));
    assign dup_front = wrap(XW'(r_front) + DEPTH_X - XW'(r_k));
    assign src_inc   = wrap(XW'(r_src) + XW'(1));
    assign dst_inc   = wrap(XW'(r_dst) + XW'(1));

    assign k_ext   = KW'(r_k);
    assign cnt_ext = KW'(r_count);

    assign rd_issue = i_cmd.copy_run && (r_idx != r_k);

    assign o_sts.req       = r_req;
    assign o_sts.full      = (cnt_ext == DEPTH_K);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.k_short   = (k_ext > cnt_ext);
    assign o_sts.k_over    = ((cnt_ext + k_ext) > DEPTH_K);
    assign o_sts.copy_done = (r_idx == r_k) && !r_wr_pend;

    // copy writes take the port in the cycle after their read
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wr_addr;
        ram_wdata = ram_rdata;
        if (r_wr_pend) begin
            ram_we = 1'b1;
        end else if (i_cmd.push_front) begin
            ram_we    = 1'b1;
            ram_waddr = front_dec;
            ram_wdata = r_item;
        end else if (i_cmd.push_back) begin
            ram_we    = 1'b1;
            ram_waddr = back_addr;
            ram_wdata = r_item;
        end
    end

    assign ram_raddr = i_cmd.copy_run ? r_src : r_front;

    dqpd_ram #(
        .W (DATA_W),
        .D (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front   <= '0;
            r_count   <= '0;
            r_wr_pend <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cmd.push_front) begin
                r_front <= front_dec;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.push_back) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_rd) begin
                r_front <= front_inc;
                r_count <= r_count - CW'(1);
            end else if (i_cmd.copy_commit) begin
                r_front <= r_new_front;
                r_count <= r_count + CW'(r_k);
            end

            if (i_cmd.copy_start) begin
                r_idx <= '0;
            end else if (rd_issue) begin
                r_idx <= r_idx + 9'd1;
            end
            r_wr_pend <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= t_req'(i_req_type);
            r_item <= item64[DATA_W-1:0];
            r_k    <= i_copy_count;
        end
        if (i_cmd.copy_start) begin
            r_src       <= r_front;
            r_dst       <= dup_front;
            r_new_front <= dup_front;
        end else if (rd_issue) begin
            r_src <= src_inc;
            r_dst <= dst_inc;
        end
        r_wr_addr <= r_dst;
        if (i_cmd.set_stat) begin
            r_stat <= i_cmd.stat;
            r_pop  <= '0;
        end else if (i_cmd.pop_cap) begin
            r_pop <= ram_rdata;
        end
        if (i_cmd.load_out) begin
            r_o_pop   <= pop64[31:0];
            r_o_stat  <= r_stat;
            r_o_empty <= (r_count == '0);
            r_o_count <= cnt64[8:0];
        end
    end

    assign o_popped_value = r_o_pop;
    assign o_status       = r_o_stat;
    assign o_is_empty     = r_o_empty;
    assign o_entry_count  = r_o_count;

endmodule

@@ src/deque_with_prefix_duplicate.sv @@
// Top level: bounded deque of handles with prefix duplicate.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------------
//  in      | sink      | i_in_valid / o_in_stall    | i_req_type, i_item_value, i_copy_count
//  out     | source    | o_out_valid / i_out_stall  | o_popped_value, o_status, o_is_empty,
//          |           |                            | o_entry_count
//
// One beat at a time: accept, decide, then load the result register.
// Push or refused request: accept, decide, respond; pop adds a step for the
// registered RAM read; duplicate of k entries does one RAM read and one write per entry
// through the single read and single write port of the entry RAM.
// A new beat is taken while the previous result still sits in the output
// register; a stalled output only holds the block in its final step.
// Synchronous active-low reset clears pointer, count and control; the entry
// RAM is not cleared.
`timescale 1ns / 1ps

module deque_with_prefix_duplicate #(
    parameter int DEPTH  = 256,
    parameter int DATA_W = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_item_value,
    input  logic [8:0]  i_copy_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_popped_value,
    output logic [1:0]  o_status,
    output logic        o_is_empty,
    output logic [8:0]  o_entry_count
);

    import dqpd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: one request in flight
    dqpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // ring store, pointers, copy engine, result register
    dqpd_dp #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_copy_count   (i_copy_count),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_is_empty     (o_is_empty),
        .o_entry_count  (o_entry_count)
    );

endmodule

@@ bench/tb.sv @@
// Testbench for the deque with prefix duplicate: directed table, then random traffic.
`timescale 1ns / 1ps

module tb;
    import dqpd_pkg::*;

    localparam int DEPTH      = 256;
    localparam int N_RANDOM   = 1450;
    localparam int STALL_PCT  = 14;
    localparam int HANG_LIMIT = 4000;   // cycles with no beat on either side
    localparam int DRAIN_WAIT = 20;     // settle time after the last result

    // One result beat as the block reports it.
    typedef struct packed {
        logic [31:0] popped;
        t_status     status;
        logic        empty;
        logic [8:0]  count;
    } deque_result_t;

    // One row of the directed table. If has_lit is set, lit is the expected
    // result written out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        t_req          req;
        logic [31:0]   value;
        logic [8:0]    k;
        logic          has_lit;
        deque_result_t lit;
    } plan_row_t;

    localparam int N_PLAN = 22;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_item_value = '0;
    logic [8:0]  i_copy_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_popped_value;
    logic [1:0]  o_status;
    logic        o_is_empty;
    logic [8:0]  o_entry_count;

    // Shadow copy of the deque: ring store, front index and fill level.
    logic [31:0] slots [DEPTH];
    logic [7:0]  front_idx = '0;
    logic [8:0]  held = '0;

    deque_result_t pending_results [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;       // no idling on either side while set
    plan_row_t   plan [N_PLAN];

    deque_with_prefix_duplicate #(
        .DEPTH  (DEPTH),
        .DATA_W (32)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_item_value   (i_item_value),
        .i_copy_count   (i_copy_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_is_empty     (o_is_empty),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Apply one request to the shadow deque and return what the block
    // should report for it. Ring indexes wrap on their own at 8 bits.
    function automatic deque_result_t deque_apply(t_req req, logic [31:0] value,
                                                  logic [8:0] k);
        deque_result_t r;
        logic [7:0]    new_front;
        r = '{popped: '0, status: ST_OK, empty: 1'b0, count: '0};
        case (req)
            REQ_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    front_idx        = front_idx - 8'd1;
                    slots[front_idx] = value;
                    held             = held + 9'd1;
                end
            end
            REQ_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slots[8'(front_idx + held)] = value;
                    held = held + 9'd1;
                end
            end
            REQ_POP_FRONT: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.popped  = slots[front_idx];
                    front_idx = front_idx + 8'd1;
                    held      = held - 9'd1;
                end
            end
            default: begin
                // Short check takes priority over the capacity check.
                if (k == 0) begin
                    r.status = ST_OK;
                end else if (k > held) begin
                    r.status = ST_SHORT;
                end else if (int'(held) + int'(k) > DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // The k slots just ahead of the front are free, no overlap.
                    new_front = front_idx - k[7:0];
                    for (int i = 0; i < k; i++)
                        slots[8'(new_front + i)] = slots[8'(front_idx + i)];
                    front_idx = new_front;
                    held      = held + k;
                end
            end
        endcase
        r.empty = (held == 0);
        r.count = held;
        return r;
    endfunction

    // Present one beat, hold it until taken, then record its expected result.
    // Random idling, skipped in the calm stretch, lowers valid first; a beat that follows another
    // directly keeps valid high with a single assignment in that step.
    task automatic send_beat(t_req req, logic [31:0] value, logic [8:0] k,
                             bit has_lit, deque_result_t lit);
        deque_result_t predicted;
        while (!calm && $urandom_range(99) < STALL_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_item_value <= value;
        i_copy_count <= k;
        do @(posedge i_clk); while (o_in_stall);
        predicted = deque_apply(req, value, k);
        pending_results.push_back(has_lit ? lit : predicted);
    endtask

    // Receiver stalls at random, except in the calm stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end

    // Result checker: every beat taken is matched against the oldest expectation.
    always @(posedge i_clk) begin
        deque_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: popped=%h status=%0d empty=%0d count=%0d",
                             o_popped_value, o_status, o_is_empty, o_entry_count);
            end else begin
                want = pending_results.pop_front();
                if (o_popped_value !== want.popped || o_status !== want.status ||
                    o_is_empty !== want.empty || o_entry_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want popped=%h status=%0d empty=%0d count=%0d, got popped=%h status=%0d empty=%0d count=%0d",
                                 want.popped, want.status, want.empty, want.count,
                                 o_popped_value, o_status, o_is_empty, o_entry_count);
                end
            end
        end
    end

    // Hang detector: no beat on either channel for too long ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int            mode;
        int            seg_left;
        int            pick;
        int            room;
        t_req          req;
        logic [8:0]    k;
        deque_result_t none;

        none = '{popped: '0, status: ST_OK, empty: 1'b0, count: '0};

        // Directed walk: empty-queue cases, extreme handles, doubling by
        // duplicate up to exactly full, then every refusal while full.
        plan = '{
            '{REQ_POP_FRONT,  32'h0000_0000, 9'd0,   1'b1, '{32'h0, ST_EMPTY, 1'b1, 9'd0}},
            '{REQ_DUP,        32'h0000_0000, 9'd0,   1'b1, '{32'h0, ST_OK,    1'b1, 9'd0}},
            '{REQ_DUP,        32'h0000_0000, 9'd256, 1'b1, '{32'h0, ST_SHORT, 1'b1, 9'd0}},
            '{REQ_PUSH_FRONT, 32'hFFFF_FFFF, 9'd0,   1'b1, '{32'h0, ST_OK,    1'b0, 9'd1}},
            '{REQ_PUSH_BACK,  32'h0000_0000, 9'd0,   1'b1, '{32'h0, ST_OK,    1'b0, 9'd2}},
            '{REQ_PUSH_FRONT, 32'hA5A5_5A5A, 9'd0,   1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd3,   1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd7,   1'b1, '{32'h0, ST_SHORT, 1'b0, 9'd6}},
            '{REQ_DUP,        32'h0000_0000, 9'd6,   1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd12,  1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd24,  1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd48,  1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd96,  1'b0, none},
            '{REQ_DUP,        32'h0000_0000, 9'd65,  1'b1, '{32'h0, ST_FULL,  1'b0, 9'd192}},
            '{REQ_DUP,        32'h0000_0000, 9'd64,  1'b1, '{32'h0, ST_OK,    1'b0, 9'd256}},
            '{REQ_PUSH_BACK,  32'h0F0F_0F0F, 9'd0,   1'b1, '{32'h0, ST_FULL,  1'b0, 9'd256}},
            '{REQ_PUSH_FRONT, 32'hF0F0_F0F0, 9'd0,   1'b1, '{32'h0, ST_FULL,  1'b0, 9'd256}},
            '{REQ_DUP,        32'h0000_0000, 9'd1,   1'b1, '{32'h0, ST_FULL,  1'b0, 9'd256}},
            '{REQ_DUP,        32'h0000_0000, 9'd0,   1'b1, '{32'h0, ST_OK,    1'b0, 9'd256}},
            '{REQ_DUP,        32'h0000_0000, 9'd511, 1'b1, '{32'h0, ST_SHORT, 1'b0, 9'd256}},
            '{REQ_POP_FRONT,  32'h0000_0000, 9'd0,   1'b0, none},
            '{REQ_PUSH_BACK,  32'h1234_5678, 9'd0,   1'b1, '{32'h0, ST_OK,    1'b0, 9'd256}}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i])
            send_beat(plan[i].req, plan[i].value, plan[i].k, plan[i].has_lit, plan[i].lit);

        // Random traffic in segments that lean strongly toward filling, toward draining, or
        // more mildly toward filling, so the deque swings between empty and full repeatedly.
        seg_left = 0;
        mode     = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 500 && n < 800);
            if (seg_left == 0) begin
                mode     = $urandom_range(2);
                seg_left = $urandom_range(40, 160);
            end
            seg_left--;
            pick = $urandom_range(99);
            case (mode)
                0:       req = pick < 30 ? REQ_PUSH_FRONT : pick < 60 ? REQ_PUSH_BACK :
                               pick < 75 ? REQ_POP_FRONT  : REQ_DUP;
                1:       req = pick < 12 ? REQ_PUSH_FRONT : pick < 24 ? REQ_PUSH_BACK :
                               pick < 80 ? REQ_POP_FRONT  : REQ_DUP;
                default: req = pick < 25 ? REQ_PUSH_FRONT : pick < 50 ? REQ_PUSH_BACK :
                               pick < 80 ? REQ_POP_FRONT  : REQ_DUP;
            endcase
            // Mostly a k that fits; otherwise zero, short, overflow or any value.
            room = (held < DEPTH - held) ? int'(held) : DEPTH - int'(held);
            k    = 9'($urandom_range(511));
            if (req == REQ_DUP) begin
                if (room >= 1 && $urandom_range(9) < 7) begin
                    k = 9'($urandom_range(1, room));
                end else begin
                    case ($urandom_range(3))
                        0:       k = 9'd0;
                        1:       k = 9'(held + 9'd1);
                        2:       k = 9'(DEPTH + 1 - int'(held));
                        default: k = 9'($urandom_range(511));
                    endcase
                end
            end
            send_beat(req, $urandom(), k, 1'b0, none);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain; the hang detector bounds this wait.
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
